[sv/lcsc_pkg.sv]
package lcsc_pkg;

  // Field widths
  localparam int unsigned SampleW  = 24;
  localparam int unsigned GramsW   = 16;
  localparam int unsigned ThrW     = 24;
  localparam int unsigned FactorW  = 16;
  localparam int unsigned FracW    = 8;
  localparam int unsigned TakenW   = 11;
  localparam int unsigned StatusW  = 2;
  localparam int unsigned ReasonW  = 3;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 24;

  // Samples averaged per calibration
  localparam int unsigned SamplesDefault = 50;

  // Register reset values
  localparam logic signed [SampleW-1:0] TareRst      = '0;
  localparam logic [ThrW-1:0]           ThresholdRst = 24'd8000;
  localparam logic [FactorW-1:0]        FactorMinRst = 16'd3840;  // 15.0
  localparam logic [FactorW-1:0]        FactorMaxRst = 16'd20480; // 80.0

  typedef enum logic [CfgIdxW-1:0] {
    REG_TARE      = 2'd0,
    REG_THRESHOLD = 2'd1,
    REG_FACTOR_MIN = 2'd2,
    REG_FACTOR_MAX = 2'd3
  } cfg_reg_e;

  typedef enum logic [StatusW-1:0] {
    STAT_BUSY = 2'd0,
    STAT_OK   = 2'd1,
    STAT_FAIL = 2'd2
  } status_e;

  typedef enum logic [ReasonW-1:0] {
    RSN_WAIT   = 3'd0,
    RSN_DETECT = 3'd1,
    RSN_SAMPLE = 3'd2,
    RSN_BADWT  = 3'd3,
    RSN_RANGE  = 3'd4,
    RSN_DONE   = 3'd5
  } reason_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_MUL,
    S_SUB,
    S_START,
    S_DIV,
    S_EMIT
  } state_e;

  typedef struct packed {
    logic start;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic               sat;
    logic [FactorW-1:0] quot;
  } div_rsp_t;

endpackage

[sv/lcsc_if.sv]
interface lcsc_item_if import lcsc_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [SampleW-1:0] sample_value;
  logic [GramsW-1:0]         reference_grams;

  modport source (output valid, output sample_value, output reference_grams, input ready);
  modport sink   (input valid, input sample_value, input reference_grams, output ready);
endinterface

interface lcsc_result_if import lcsc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [StatusW-1:0] status;
  logic [ReasonW-1:0] reason;
  logic [FactorW-1:0] factor_out;
  logic [TakenW-1:0]  samples_taken;

  modport source (output valid, output status, output reason, output factor_out,
                  output samples_taken, input ready);
  modport sink   (input valid, input status, input reason, input factor_out,
                  input samples_taken, output ready);
endinterface

interface lcsc_cfg_if import lcsc_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[sv/lcsc_div.sv]
// Restoring divider, one quotient bit per cycle, with saturation pre-check.
module lcsc_div import lcsc_pkg::*; #(
  parameter int unsigned NumW = 31,
  parameter int unsigned DenW = 22
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  div_req_t               req_i,
  input  logic signed [NumW-1:0] num_i,
  input  logic [DenW-1:0]        den_i,
  output div_rsp_t               rsp_o
);

  localparam int unsigned StepW = $clog2(FactorW + 1);

  logic               run_q, run_d;
  logic               done_q, done_d;
  logic [StepW-1:0]   cnt_q, cnt_d;
  logic [DenW-1:0]    rem_q, rem_d;
  logic [FactorW-1:0] bits_q, bits_d;
  logic [FactorW-1:0] quot_q, quot_d;
  logic               sat_q, sat_d;

  logic [DenW:0] part;
  logic          ge;
  logic          too_big;

  assign part    = {rem_q, bits_q[FactorW-1]};
  assign ge      = part >= {1'b0, den_i};
  // quotient would not fit in FactorW bits
  assign too_big = num_i[NumW-2:0] >= {den_i, {FracW{1'b0}}};

  always_comb begin
    run_d  = run_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    bits_d = bits_q;
    quot_d = quot_q;
    sat_d  = sat_q;
    done_d = 1'b0;
    if (req_i.start) begin
      if (num_i[NumW-1] || too_big) begin
        sat_d  = 1'b1;
        done_d = 1'b1;
        run_d  = 1'b0;
      end else begin
        rem_d  = num_i[NumW-2:FracW];
        bits_d = {num_i[FracW-1:0], {FracW{1'b0}}};
        quot_d = '0;
        cnt_d  = StepW'(FactorW);
        sat_d  = 1'b0;
        run_d  = 1'b1;
      end
    end else if (run_q) begin
      rem_d  = ge ? DenW'(part - {1'b0, den_i}) : part[DenW-1:0];
      quot_d = {quot_q[FactorW-2:0], ge};
      bits_d = bits_q << 1;
      cnt_d  = cnt_q - StepW'(1);
      if (cnt_q == StepW'(1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    bits_q <= bits_d;
    quot_q <= quot_d;
    sat_q  <= sat_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.sat  = sat_q;
  assign rsp_o.quot = quot_q;

endmodule

[sv/load_cell_span_calibrator_core.sv]
// Single-point span calibration of a load cell.
// item_i   : one raw sample (signed 24 bit) and the reference weight in grams.
// result_o : one item per input item: status, reason, Q8.8 factor, samples taken.
// cfg_i    : register writes (tare, detect threshold, factor min, factor max),
//            always ready; write only while no input item is in flight.
// While waiting, a sample whose net value exceeds the threshold starts a run
// (a zero weight fails at once). The next Samples items are summed; the last
// one triggers the factor ((sum - Samples*tare) * 256) / (Samples*weight).
// Wait, detect and sample items go from accept through EVAL and EMIT to the
// output register; the last sample of a run also passes MUL, SUB, START and
// the 16-step restoring divider (its steps skipped when the factor saturates).
// Only one item is in flight; item_i.ready is high only while the sequencer is
// idle, so the next item is taken only once the last result has left EMIT.
// Results sit in an output register, so the next item is taken while the
// receiver stalls; a further result waits in the sequencer until the
// register drains. Reset clears the run and loads the register defaults.
module load_cell_span_calibrator_core import lcsc_pkg::*; #(
  parameter int unsigned Samples = SamplesDefault
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  lcsc_item_if.sink      item_i,
  lcsc_result_if.source  result_o,
  lcsc_cfg_if.sink       cfg_i
);

  localparam int unsigned Lg   = $clog2(Samples);
  localparam int unsigned CntW = $clog2(Samples + 1);
  localparam int unsigned SumW = SampleW + Lg;   // |sum| <= Samples * 2^23
  localparam int unsigned NumW = SumW + 1;
  localparam int unsigned DenW = GramsW + Lg;
  localparam int unsigned CmpW = SampleW + 2;

  localparam logic signed [SumW-1:0] SamplesS = SumW'(Samples);
  localparam logic [DenW-1:0]        SamplesU = DenW'(Samples);
  localparam logic [CntW-1:0]        LastCnt  = CntW'(Samples - 1);

  // configuration registers
  logic signed [SampleW-1:0] tare_q;
  logic [ThrW-1:0]           thr_q;
  logic [FactorW-1:0]        fmin_q;
  logic [FactorW-1:0]        fmax_q;

  state_e state_q, state_d;

  // captured item
  logic signed [SampleW-1:0] sample_q;
  logic [GramsW-1:0]         grams_q;

  // run state
  logic                   phase_q, phase_d;
  logic [CntW-1:0]        tally_q, tally_d;
  logic signed [SumW-1:0] sum_q, sum_d;
  logic [GramsW-1:0]      weight_q, weight_d;

  // factor operands
  logic signed [SumW-1:0] prod_q;
  logic [DenW-1:0]        den_q;
  logic signed [NumW-1:0] num_q;

  // pending result
  status_e            res_status_q, res_status_d;
  reason_e            res_reason_q, res_reason_d;
  logic [FactorW-1:0] res_factor_q, res_factor_d;
  logic [TakenW-1:0]  res_taken_q, res_taken_d;

  // output register
  logic               out_valid_q, out_valid_d;
  status_e            out_status_q;
  reason_e            out_reason_q;
  logic [FactorW-1:0] out_factor_q;
  logic [TakenW-1:0]  out_taken_q;

  logic in_acc, out_free, last;
  logic signed [CmpW-1:0] net, thr_x;
  logic detect;

  div_req_t div_req;
  div_rsp_t div_rsp;

  assign item_i.ready = (state_q == S_IDLE);
  assign in_acc       = item_i.valid && item_i.ready;
  assign out_free     = !out_valid_q || result_o.ready;
  assign last         = (tally_q == LastCnt);

  assign net    = CmpW'(sample_q) - CmpW'(tare_q);
  assign thr_x  = signed'(CmpW'(thr_q));
  assign detect = net > thr_x;

  assign div_req.start = (state_q == S_START) && (den_q != '0);

  lcsc_div #(
    .NumW (NumW),
    .DenW (DenW)
  ) u_lcsc_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .num_i  (num_q),
    .den_i  (den_q),
    .rsp_o  (div_rsp)
  );

  // configuration port
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tare_q <= TareRst;
      thr_q  <= ThresholdRst;
      fmin_q <= FactorMinRst;
      fmax_q <= FactorMaxRst;
    end else if (cfg_i.valid) begin
      unique case (cfg_reg_e'(cfg_i.index))
        REG_TARE:       tare_q <= signed'(cfg_i.data[SampleW-1:0]);
        REG_THRESHOLD:  thr_q  <= cfg_i.data[ThrW-1:0];
        REG_FACTOR_MIN: fmin_q <= cfg_i.data[FactorW-1:0];
        REG_FACTOR_MAX: fmax_q <= cfg_i.data[FactorW-1:0];
      endcase
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (in_acc) state_d = S_EVAL;
      S_EVAL:  state_d = (phase_q && last) ? S_MUL : S_EMIT;
      S_MUL:   state_d = S_SUB;
      S_SUB:   state_d = S_START;
      S_START: state_d = (den_q == '0) ? S_EMIT : S_DIV;
      S_DIV:   if (div_rsp.done) state_d = S_EMIT;
      S_EMIT:  if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    phase_d      = phase_q;
    tally_d      = tally_q;
    sum_d        = sum_q;
    weight_d     = weight_q;
    res_status_d = res_status_q;
    res_reason_d = res_reason_q;
    res_factor_d = res_factor_q;
    res_taken_d  = res_taken_q;
    out_valid_d  = out_valid_q && !result_o.ready;
    unique case (state_q)
      S_EVAL: begin
        res_factor_d = '0;
        res_taken_d  = '0;
        if (!phase_q) begin
          if (!detect) begin
            res_status_d = STAT_BUSY;
            res_reason_d = RSN_WAIT;
          end else begin
            weight_d = grams_q;
            if (grams_q == '0) begin
              res_status_d = STAT_FAIL;
              res_reason_d = RSN_BADWT;
            end else begin
              phase_d      = 1'b1;
              sum_d        = '0;
              tally_d      = '0;
              res_status_d = STAT_BUSY;
              res_reason_d = RSN_DETECT;
            end
          end
        end else begin
          sum_d = sum_q + SumW'(sample_q);
          if (!last) begin
            tally_d      = tally_q + CntW'(1);
            res_status_d = STAT_BUSY;
            res_reason_d = RSN_SAMPLE;
            res_taken_d  = TakenW'(tally_q + CntW'(1));
          end else begin
            // run complete: back to waiting, factor worked out next
            phase_d     = 1'b0;
            tally_d     = '0;
            res_taken_d = TakenW'(Samples);
          end
        end
      end
      S_START: begin
        if (den_q == '0) begin
          res_status_d = STAT_FAIL;
          res_reason_d = RSN_BADWT;
          res_factor_d = '0;
        end
      end
      S_DIV: begin
        if (div_rsp.done) begin
          if (div_rsp.sat || (div_rsp.quot < fmin_q) || (div_rsp.quot > fmax_q)) begin
            res_status_d = STAT_FAIL;
            res_reason_d = RSN_RANGE;
            res_factor_d = '0;
          end else begin
            res_status_d = STAT_OK;
            res_reason_d = RSN_DONE;
            res_factor_d = div_rsp.quot;
          end
        end
      end
      S_EMIT: begin
        if (out_free) out_valid_d = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      phase_q     <= 1'b0;
      tally_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      tally_q     <= tally_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      sample_q <= item_i.sample_value;
      grams_q  <= item_i.reference_grams;
    end
    sum_q        <= sum_d;
    weight_q     <= weight_d;
    res_status_q <= res_status_d;
    res_reason_q <= res_reason_d;
    res_factor_q <= res_factor_d;
    res_taken_q  <= res_taken_d;
    if (state_q == S_MUL) begin
      prod_q <= SumW'(SumW'(tare_q) * SamplesS);
      den_q  <= DenW'(DenW'(weight_q) * SamplesU);
    end
    if (state_q == S_SUB) num_q <= NumW'(sum_q) - NumW'(prod_q);
    if (state_q == S_EMIT && out_free) begin
      out_status_q <= res_status_q;
      out_reason_q <= res_reason_q;
      out_factor_q <= res_factor_q;
      out_taken_q  <= res_taken_q;
    end
  end

  assign result_o.valid         = out_valid_q;
  assign result_o.status        = out_status_q;
  assign result_o.reason        = out_reason_q;
  assign result_o.factor_out    = out_factor_q;
  assign result_o.samples_taken = out_taken_q;

endmodule

[sv/lcsc_checker.sv]
module lcsc_checker import lcsc_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_i,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input logic [StatusW-1:0] status_i,
  input logic [ReasonW-1:0] reason_i,
  input logic [FactorW-1:0] factor_i,
  input logic [TakenW-1:0]  taken_i
);

  // one item in flight: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("accepted a second item back to back");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(status_i) &&
    $stable(reason_i) && $stable(factor_i) && $stable(taken_i))
    else $error("stalled result changed");

  a_ok_iff_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> ((status_i == STAT_OK) == (reason_i == RSN_DONE)))
    else $error("status and reason disagree");

  a_factor_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (status_i != STAT_OK) |-> (factor_i == '0))
    else $error("factor shown without success");

  a_taken_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (reason_i == RSN_WAIT || reason_i == RSN_DETECT) |-> (taken_i == '0))
    else $error("sample count shown outside a run");

endmodule

bind load_cell_span_calibrator_core lcsc_checker u_lcsc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (item_i.valid),
  .in_ready_i  (item_i.ready),
  .out_valid_i (result_o.valid),
  .out_ready_i (result_o.ready),
  .status_i    (result_o.status),
  .reason_i    (result_o.reason),
  .factor_i    (result_o.factor_out),
  .taken_i     (result_o.samples_taken)
);

[tb/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
  import lcsc_pkg::*;

  localparam int unsigned CAL_SAMPLES = SamplesDefault;
  localparam int unsigned STALL_LIMIT = 5000; // cycles with no handshake at all
  localparam int unsigned SETTLE_CYCLES = 30; // idle time after the last result has been taken

  typedef struct {
    status_e            status;
    reason_e            reason;
    logic [FactorW-1:0] factor;
    logic [TakenW-1:0]  taken;
  } cal_result_t;

  logic clk = 1'b0;
  logic rst_n;

  lcsc_item_if   item_if ();
  lcsc_result_if res_if ();
  lcsc_cfg_if    cfg_if ();

  load_cell_span_calibrator_core #(
    .Samples(CAL_SAMPLES)
  ) dut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .item_i  (item_if),
    .result_o(res_if),
    .cfg_i   (cfg_if)
  );

  always #1 clk = ~clk;

  // Register copies
  logic signed [SampleW-1:0] cfg_tare      = TareRst;
  logic [ThrW-1:0]           cfg_threshold = ThresholdRst;
  logic [FactorW-1:0]        cfg_fmin      = FactorMinRst;
  logic [FactorW-1:0]        cfg_fmax      = FactorMaxRst;

  // Calibration state copies
  logic              cal_active = 1'b0;
  longint            cal_sum    = 0;
  int unsigned       cal_tally  = 0;
  logic [GramsW-1:0] cal_weight = '0;

  cal_result_t pending_results[$];
  int          mismatch_count = 0;

  // Traffic shaping
  int burst_left = 0;
  int max_gap    = 0;
  int ready_pct  = 100;
  int stall_left = 0;
  int hold_left  = 0;

  function automatic cal_result_t make_result(status_e st, reason_e rs,
                                              logic [FactorW-1:0] f, logic [TakenW-1:0] n);
    cal_result_t r;
    r.status = st;
    r.reason = rs;
    r.factor = f;
    r.taken  = n;
    return r;
  endfunction

  // Advances the state copy by one accepted item and gives the result it causes.
  function automatic cal_result_t predict_calibration(logic signed [SampleW-1:0] smp,
                                                      logic [GramsW-1:0] grams);
    longint      net;
    longint      num;
    longint      den;
    longint      quot;
    int unsigned taken;
    if (!cal_active) begin
      net = longint'(smp) - longint'(cfg_tare);
      if (net <= longint'(cfg_threshold))
        return make_result(STAT_BUSY, RSN_WAIT, '0, '0);
      cal_weight = grams;
      if (grams == '0)
        return make_result(STAT_FAIL, RSN_BADWT, '0, '0);
      cal_active = 1'b1;
      cal_sum    = 0;
      cal_tally  = 0;
      return make_result(STAT_BUSY, RSN_DETECT, '0, '0);
    end
    cal_sum   = cal_sum + longint'(smp);
    cal_tally = cal_tally + 1;
    if (cal_tally < CAL_SAMPLES)
      return make_result(STAT_BUSY, RSN_SAMPLE, '0, TakenW'(cal_tally));
    taken      = cal_tally;
    num        = cal_sum - longint'(CAL_SAMPLES) * longint'(cfg_tare);
    den        = longint'(CAL_SAMPLES) * longint'(cal_weight);
    cal_active = 1'b0;
    cal_tally  = 0;
    cal_sum    = 0;
    if (den == 0)
      return make_result(STAT_FAIL, RSN_BADWT, '0, TakenW'(taken));
    // saturation on either side always fails the range test
    if (num < 0)
      return make_result(STAT_FAIL, RSN_RANGE, '0, TakenW'(taken));
    quot = (num * 256) / den;
    if (quot > 65535 || quot < longint'(cfg_fmin) || quot > longint'(cfg_fmax))
      return make_result(STAT_FAIL, RSN_RANGE, '0, TakenW'(taken));
    return make_result(STAT_OK, RSN_DONE, FactorW'(quot), TakenW'(taken));
  endfunction

  function automatic logic signed [SampleW-1:0] clamp24(longint v);
    if (v > 64'sd8388607)
      return 24'sh7FFFFF;
    if (v < -64'sd8388608)
      return 24'sh800000;
    return SampleW'(v);
  endfunction

  task automatic report_error(string msg);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("%0t: %s", $realtime, msg);
  endtask

  // Sender: bursts of random length with random gaps; called and returns at a falling edge.
  task automatic send_item(logic signed [SampleW-1:0] smp, logic [GramsW-1:0] grams);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, max_gap);
      if (gap > 0) begin
        item_if.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    item_if.valid           <= 1'b1;
    item_if.sample_value    <= smp;
    item_if.reference_grams <= grams;
    do @(posedge clk); while (!item_if.ready);
    pending_results.push_back(predict_calibration(smp, grams));
    @(negedge clk);
  endtask

  // Sender pauses until every result is back, then lets the block settle.
  task automatic wait_idle();
    item_if.valid <= 1'b0;
    burst_left = 0;
    while (pending_results.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [CfgDataW-1:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    do @(posedge clk); while (!cfg_if.ready);
    case (idx)
      REG_TARE:       cfg_tare      = data;
      REG_THRESHOLD:  cfg_threshold = data;
      REG_FACTOR_MIN: cfg_fmin      = data[FactorW-1:0];
      REG_FACTOR_MAX: cfg_fmax      = data[FactorW-1:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic set_config(longint tare, longint threshold, longint fmin, longint fmax);
    wait_idle();
    write_reg(REG_TARE, CfgDataW'(tare));
    write_reg(REG_THRESHOLD, CfgDataW'(threshold));
    write_reg(REG_FACTOR_MIN, CfgDataW'(fmin));
    write_reg(REG_FACTOR_MAX, CfgDataW'(fmax));
    cfg_if.valid <= 1'b0;
  endtask

  // Samples centred so that the mean gives the wanted Q8.8 factor for the latched weight.
  task automatic sample_burst(longint factor_q8, int amp);
    longint centre;
    centre = longint'(cfg_tare) + (factor_q8 * longint'(cal_weight)) / 256;
    repeat (CAL_SAMPLES)
      send_item(clamp24(centre + longint'($urandom_range(0, 2 * amp)) - amp),
                GramsW'($urandom()));
  endtask

  // One detection item and, if a run started, its full set of samples.
  task automatic cal_run(logic [GramsW-1:0] grams, longint factor_q8, int amp);
    send_item(clamp24(longint'(cfg_tare) + longint'(cfg_threshold) + 1
                      + longint'($urandom_range(0, amp))), grams);
    if (cal_active)
      sample_burst(factor_q8, amp);
  endtask

  task automatic random_session();
    int                noise_n;
    int                pick;
    logic [GramsW-1:0] grams;
    longint            target;
    int                amp;
    noise_n = $urandom_range(0, 4);
    repeat (noise_n) begin
      if ($urandom_range(0, 4) == 0)
        send_item(SampleW'($urandom()), GramsW'($urandom()));
      else
        send_item(clamp24(longint'(cfg_tare) + longint'(cfg_threshold)
                          - longint'($urandom_range(0, 100000))), GramsW'($urandom()));
    end
    pick = $urandom_range(0, 9);
    if (pick == 0)
      grams = '0;
    else if (pick < 5)
      grams = GramsW'($urandom_range(1, 5000));
    else
      grams = GramsW'($urandom_range(1, 65535));
    pick = $urandom_range(0, 19);
    if (pick < 14) begin
      if (cfg_fmin <= cfg_fmax)
        target = $urandom_range(cfg_fmin, cfg_fmax);
      else
        target = $urandom_range(0, 65535);
    end else if (pick < 17) begin
      target = longint'(cfg_fmin) - longint'($urandom_range(1, 2000));
    end else begin
      target = longint'(cfg_fmax) + longint'($urandom_range(1, 30000));
    end
    amp = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 3000);
    cal_run(grams, target, amp);
  endtask

  // Threshold edge, sample extremes, zero weight, then a clean run at factor_max.
  task automatic test_detection();
    ready_pct = 70;
    max_gap   = 3;
    send_item(24'sd8000, 16'hFFFF);
    send_item(24'sh800000, 16'h0000);
    send_item(24'sd8001, 16'h0000);
    send_item(24'sh7FFFFF, 16'hFFFF);
    sample_burst(longint'(cfg_fmax), 0);
  endtask

  // Weight 256 makes the factor equal to mean minus tare, so limits are hit exactly.
  task automatic test_factor_edges();
    ready_pct = 85;
    max_gap   = 2;
    cal_run(16'd256, longint'(cfg_fmin), 0);
    cal_run(16'd256, longint'(cfg_fmin) - 1, 0);
    cal_run(16'd1, 64'sd1 << 40, 0);     // pinned at the top sample: factor saturates high
    cal_run(16'd300, -(64'sd1 << 40), 0); // pinned at the bottom sample: negative numerator
  endtask

  task automatic test_config_extremes();
    ready_pct = 60;
    max_gap   = 4;
    set_config(-8388608, 0, 0, 65535);
    cal_run(16'd256, 0, 0);              // zero factor accepted with a zero minimum
    set_config(8388607, 16777215, 65535, 0);
    send_item(24'sh7FFFFF, 16'hFFFF);
    send_item(24'sh800000, 16'h0001);
    send_item(SampleW'($urandom()), GramsW'($urandom()));
    send_item(24'sd0, 16'h8000);
    set_config(0, 1000, 30000, 100);     // minimum above maximum: nothing passes
    cal_run(16'd256, 5000, 200);
  endtask

  // Receiver holds off while the sender keeps offering, so the input stalls.
  task automatic test_backpressure();
    set_config(TareRst, ThresholdRst, FactorMinRst, FactorMaxRst);
    ready_pct = 100;
    max_gap   = 0;
    hold_left = 400;
    cal_run(16'd500, 10000, 1000);
    wait_idle();
  endtask

  task automatic test_random();
    int     phase;
    longint fmin;
    for (phase = 0; phase < 5; phase++) begin
      if (phase == 4) begin
        set_config(TareRst, ThresholdRst, FactorMinRst, FactorMaxRst);
      end else begin
        fmin = $urandom_range(0, 20000);
        set_config(longint'($urandom_range(0, 4000000)) - 2000000,
                   $urandom_range(0, 200000), fmin,
                   (fmin + $urandom_range(0, 40000) > 65535) ? 65535
                                                            : fmin + $urandom_range(0, 40000));
      end
      // phase 1 runs without idling on either side
      ready_pct = (phase == 1) ? 100 : $urandom_range(30, 95);
      max_gap   = (phase == 1) ? 0 : $urandom_range(1, 12);
      repeat (2) random_session();
    end
  endtask

  // Receiver stall pattern: random stretches of low ready, or a long hold when asked.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      res_if.ready <= 1'b0;
      hold_left--;
    end else if (stall_left > 0) begin
      res_if.ready <= 1'b0;
      stall_left--;
    end else if ($urandom_range(0, 99) < ready_pct) begin
      res_if.ready <= 1'b1;
    end else begin
      res_if.ready <= 1'b0;
      stall_left = $urandom_range(0, 5);
    end
  end

  // Result checker: oldest pending result against each accepted result item.
  always @(posedge clk) begin
    cal_result_t exp_r;
    if (rst_n && res_if.valid && res_if.ready) begin
      if (pending_results.size() == 0) begin
        report_error("result item arrived with nothing pending");
      end else begin
        exp_r = pending_results.pop_front();
        if (res_if.status !== exp_r.status || res_if.reason !== exp_r.reason
            || res_if.factor_out !== exp_r.factor || res_if.samples_taken !== exp_r.taken)
          report_error($sformatf({"result mismatch: expected status %0d reason %0d ",
                                  "factor %0d taken %0d, got status %0d reason %0d ",
                                  "factor %0d taken %0d"},
                                 exp_r.status, exp_r.reason, exp_r.factor, exp_r.taken,
                                 res_if.status, res_if.reason, res_if.factor_out,
                                 res_if.samples_taken));
      end
    end
  end

  // Watchdog: ends the run when no handshake happens for too long.
  initial begin
    int unsigned idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((item_if.valid && item_if.ready) || (res_if.valid && res_if.ready)
          || (cfg_if.valid && cfg_if.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("Verification failed");
    $finish;
  end

  initial begin
    item_if.valid           = 1'b0;
    item_if.sample_value    = '0;
    item_if.reference_grams = '0;
    cfg_if.valid            = 1'b0;
    cfg_if.index            = REG_TARE;
    cfg_if.data             = '0;
    res_if.ready            = 1'b0;
    rst_n                   = 1'b0;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_detection();
    test_factor_edges();
    test_config_extremes();
    test_backpressure();
    test_random();

    wait_idle();
    if (mismatch_count == 0 && pending_results.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

[files.f]
sv/lcsc_pkg.sv
sv/lcsc_if.sv
sv/lcsc_div.sv
sv/load_cell_span_calibrator_core.sv
sv/lcsc_checker.sv
tb/tb_top.sv
